[rtl/fau_pkg.sv]
// Shared types and constants of the fractional anisotropy unit.
`timescale 1ns / 1ps
`default_nettype none
package fau_pkg;

	localparam int CFG_WIDTH = 48;
	localparam int FA_WIDTH  = 16;
	localparam logic [CFG_WIDTH-1:0] MIN_ENERGY_RST = 48'd1;

	// per-item control that travels from front to back
	typedef struct packed {
		logic last;
		logic low;
		logic sat;
	} fa_ctl_t;

endpackage
`default_nettype wire

[rtl/fau_if.sv]
// Valid/ready channel interfaces for eigenvalue items and anisotropy items.
`timescale 1ns / 1ps
`default_nettype none
interface fau_eig_if #(parameter int EIGEN_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic signed [EIGEN_BITS-1:0] eig_first;
	logic signed [EIGEN_BITS-1:0] eig_second;
	logic signed [EIGEN_BITS-1:0] eig_third;
	logic                         last_voxel;

	modport source (output valid, eig_first, eig_second, eig_third, last_voxel, input ready);
	modport sink (input valid, eig_first, eig_second, eig_third, last_voxel, output ready);
endinterface

interface fau_fa_if;
	logic        valid;
	logic        ready;
	logic [15:0] anisotropy;
	logic        low_energy;
	logic        last_out;

	modport source (output valid, anisotropy, low_energy, last_out, input ready);
	modport sink (input valid, anisotropy, low_energy, last_out, output ready);
endinterface
`default_nettype wire

[rtl/fractional_anisotropy_unit.sv]
// Top level of the fractional anisotropy unit.
// Takes one voxel's three signed eigenvalues per item and returns its fractional
// anisotropy as unsigned fixed point with FA_FRAC_BITS fraction bits (saturated at
// 1.0), a low-energy flag and the last-voxel mark. One item is accepted every
// cycle unless a full queue stalls the front; an item passes 3 front stages, the
// 4-entry queue and 3*FA_FRAC_BITS back stages (2*FA_FRAC_BITS divider bits, then
// FA_FRAC_BITS root bits, one per stage). min_energy resets to 1; the user must write
// it through cfg_we/cfg_wdata only while the unit is idle; the block has no check.
`timescale 1ns / 1ps
`default_nettype none
module fractional_anisotropy_unit #(
	parameter int EIGEN_BITS   = 24,
	parameter int FA_FRAC_BITS = 15
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [fau_pkg::CFG_WIDTH-1:0] cfg_wdata,
	fau_eig_if.sink                            eig,
	fau_fa_if.source                           fa
);
	import fau_pkg::*;

	localparam int NW = 2 * EIGEN_BITS + 2;
	localparam int DW = 2 * EIGEN_BITS + 1;
	localparam int CTW = $bits(fa_ctl_t);
	localparam int QDW = CTW + NW + DW;

	logic [CFG_WIDTH-1:0] min_energy_q;
	logic                 push_valid, push_ready, pop_valid, pop_ready;
	fa_ctl_t              push_ctl, pop_ctl;
	logic [NW-1:0]        push_num, pop_num;
	logic [DW-1:0]        push_den, pop_den;
	logic [QDW-1:0]       pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_energy_q <= MIN_ENERGY_RST;
		else if (cfg_we) min_energy_q <= cfg_wdata;
	end

	fau_front #(.EIGEN_BITS(EIGEN_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.min_energy (min_energy_q),
		.eig        (eig),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_ctl   (push_ctl),
		.push_num   (push_num),
		.push_den   (push_den)
	);

	fau_queue #(.WIDTH(QDW), .DEPTH(4)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_data   ({push_ctl, push_num, push_den}),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_data  (pop_data)
	);

	assign pop_ctl = pop_data[QDW-1 -: CTW];
	assign pop_num = pop_data[NW+DW-1 -: NW];
	assign pop_den = pop_data[DW-1:0];

	fau_back #(.EIGEN_BITS(EIGEN_BITS), .FA_FRAC_BITS(FA_FRAC_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_ready (pop_ready),
		.q_ctl   (pop_ctl),
		.q_num   (pop_num),
		.q_den   (pop_den),
		.fa      (fa)
	);

endmodule
`default_nettype wire

[rtl/fau_front.sv]
// Front end: squares, sums, energy test and saturation test for each item.
`timescale 1ns / 1ps
`default_nettype none
module fau_front #(
	parameter int EIGEN_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [fau_pkg::CFG_WIDTH-1:0]   min_energy,
	fau_eig_if.sink                              eig,
	output logic                                 push_valid,
	input  wire logic                            push_ready,
	output fau_pkg::fa_ctl_t                     push_ctl,
	output logic [2*EIGEN_BITS+1:0]              push_num,
	output logic [2*EIGEN_BITS:0]                push_den
);
	import fau_pkg::*;

	localparam int EB = EIGEN_BITS;
	localparam int SW = 2 * EB;
	localparam int NW = 2 * EB + 2;
	localparam int DW = 2 * EB + 1;
	localparam int CW = (SW > CFG_WIDTH) ? SW : CFG_WIDTH;

	logic          en;
	logic [EB-1:0] m1, m2, m3;
	logic [SW-1:0] p1, p2, p3;
	logic [EB:0]   as1;
	logic [NW-1:0] s1sq;

	logic                 vld_s1, vld_s2, vld_s3;
	logic                 last_s1, last_s2, last_s3;
	logic [SW-1:0]        sq1_s1, sq2_s1, sq3_s1;
	logic signed [EB+1:0] sum_s1;
	logic [SW-1:0]        s2_s2;
	logic [NW-1:0]        s1sq_s2;
	logic                 low_s3;
	logic [NW-1:0]        num_s3;
	logic [DW-1:0]        den_s3;

	assign en        = !vld_s3 || push_ready;
	assign eig.ready = en;

	assign m1 = eig.eig_first[EB-1]  ? EB'(-eig.eig_first)  : EB'(eig.eig_first);
	assign m2 = eig.eig_second[EB-1] ? EB'(-eig.eig_second) : EB'(eig.eig_second);
	assign m3 = eig.eig_third[EB-1]  ? EB'(-eig.eig_third)  : EB'(eig.eig_third);
	assign p1 = SW'(m1) * SW'(m1);
	assign p2 = SW'(m2) * SW'(m2);
	assign p3 = SW'(m3) * SW'(m3);

	assign as1  = sum_s1[EB+1] ? (EB+1)'(-sum_s1) : (EB+1)'(sum_s1);
	assign s1sq = NW'(as1) * NW'(as1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= eig.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq1_s1  <= p1;
			sq2_s1  <= p2;
			sq3_s1  <= p3;
			sum_s1  <= (EB+2)'(eig.eig_first) + (EB+2)'(eig.eig_second)
				+ (EB+2)'(eig.eig_third);
			last_s1 <= eig.last_voxel;
			s2_s2   <= sq1_s1 + sq2_s1 + sq3_s1;
			s1sq_s2 <= s1sq;
			last_s2 <= last_s1;
			low_s3  <= (CW'(s2_s2) < CW'(min_energy)) || (s2_s2 == '0);
			num_s3  <= NW'({s2_s2, 1'b0}) + NW'(s2_s2) - s1sq_s2;
			den_s3  <= {s2_s2, 1'b0};
			last_s3 <= last_s2;
		end
	end

	assign push_valid    = vld_s3;
	assign push_ctl.last = last_s3;
	assign push_ctl.low  = low_s3;
	assign push_ctl.sat  = num_s3 >= NW'(den_s3);
	assign push_num      = num_s3;
	assign push_den      = den_s3;

endmodule
`default_nettype wire

[rtl/fau_queue.sv]
// Short register FIFO between front and back.
`timescale 1ns / 1ps
`default_nettype none
module fau_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      out_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CNTW-1:0]  cnt_q;
	logic             push, pop;

	assign in_ready  = cnt_q != CNTW'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			if (pop)  rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= in_data;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(DEPTH)) else $error("queue count over depth");
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count lost a push");

endmodule
`default_nettype wire

[rtl/fau_back.sv]
// Back end: pipelined restoring divider followed by a pipelined square root.
`timescale 1ns / 1ps
`default_nettype none
module fau_back #(
	parameter int EIGEN_BITS   = 24,
	parameter int FA_FRAC_BITS = 15
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_valid,
	output logic                            q_ready,
	input  wire fau_pkg::fa_ctl_t           q_ctl,
	input  wire logic [2*EIGEN_BITS+1:0]    q_num,
	input  wire logic [2*EIGEN_BITS:0]      q_den,
	fau_fa_if.source                        fa
);
	import fau_pkg::*;

	localparam int F  = FA_FRAC_BITS;
	localparam int NW = 2 * EIGEN_BITS + 2;
	localparam int DW = 2 * EIGEN_BITS + 1;
	localparam int QW = 2 * F;
	localparam int D  = 3 * F;

	typedef struct packed {
		logic          last;
		logic          low;
		logic          sat;
		logic [NW-1:0] rem;
		logic [DW-1:0] den;
		logic [QW-1:0] quo;
		logic [F+1:0]  srem;
		logic [F-1:0]  root;
	} stage_t;

	function automatic stage_t div_step(input stage_t s);
		stage_t      r;
		logic [NW:0] r2;
		logic        ge;
		r     = s;
		r2    = {s.rem, 1'b0};
		ge    = r2 >= (NW+1)'(s.den);
		r.rem = ge ? NW'(r2 - (NW+1)'(s.den)) : NW'(r2);
		r.quo = {s.quo[QW-2:0], ge};
		return r;
	endfunction

	function automatic stage_t sqrt_step(input stage_t s, input int j);
		stage_t       r;
		logic [F+3:0] t;
		logic [F+3:0] trial;
		logic         ge;
		r      = s;
		t      = {s.srem, s.quo[QW-1-2*j -: 2]};
		trial  = (F+4)'({s.root, 2'b01});
		ge     = t >= trial;
		r.srem = ge ? (F+2)'(t - trial) : (F+2)'(t);
		r.root = {s.root[F-2:0], ge};
		return r;
	endfunction

	stage_t         pipe_s [D];
	stage_t         nxt [D];
	stage_t         head;
	logic [D-1:0]   vld_s;
	logic           adv;
	logic [F:0]     fa_full;
	logic [F+16:0]  fa_ext;

	assign adv     = !vld_s[D-1] || fa.ready;
	assign q_ready = adv;

	always_comb begin
		head      = '0;
		head.last = q_ctl.last;
		head.low  = q_ctl.low;
		head.sat  = q_ctl.sat;
		head.rem  = q_num;
		head.den  = q_den;
	end

	for (genvar k = 0; k < D; k++) begin : g_stage
		if (k == 0) begin : g_div_first
			always_comb nxt[k] = div_step(head);
		end else if (k < QW) begin : g_div
			always_comb nxt[k] = div_step(pipe_s[k-1]);
		end else begin : g_root
			always_comb nxt[k] = sqrt_step(pipe_s[k-1], k - QW);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= (k == 0) ? q_valid : vld_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) pipe_s[k] <= nxt[k];
		end
	end

	assign fa_full       = pipe_s[D-1].sat ? ((F+1)'(1) << F) : {1'b0, pipe_s[D-1].root};
	assign fa_ext        = (F+17)'(fa_full);
	assign fa.valid      = vld_s[D-1];
	assign fa.anisotropy = pipe_s[D-1].low ? '0 : fa_ext[15:0];
	assign fa.low_energy = pipe_s[D-1].low;
	assign fa.last_out   = pipe_s[D-1].last;

	a_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fa.valid && fa.low_energy |-> fa.anisotropy == '0) else $error("low energy item not zero");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && adv |=> vld_s[0]) else $error("popped item lost at back entry");

endmodule
`default_nettype wire
